### sv/tkfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkfst_pkg
// Shared types and codes of the time-keyed flash slot table.
// ----------------------------------------------------------------------------
package tkfst_pkg;

    localparam int ACTION_W = 3;
    localparam int TIME_W   = 31;
    localparam int SIDX_W   = 5;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 32;
    localparam int WP_W     = 10;
    localparam int EIU_W    = 6;
    localparam int CFG_IDX_W = 2;

    // A slot is 512 bytes
    localparam int SLOT_SHIFT = 9;

    localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_READ_IDX = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_TIME = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_IDX  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RESET    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_RELOC  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SLOTS = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] key;
        logic [ADDR_W-1:0] loc;
    } entry_t;

endpackage

### sv/tkfst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkfst_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and read enable.
// ----------------------------------------------------------------------------
module tkfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/timestamp_keyed_flash_slot_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_keyed_flash_slot_table_unit
// Table from execution time to 512-byte flash slot, with append-only slot
// pointer and compaction that emits relocation commands.
// ----------------------------------------------------------------------------
// The block takes one item at a time and stalls its input until the last
// result of that item has been loaded into the output register. It can take
// the next item in the cycle after that load. Entries sit in a RAM with one
// read port, visited one entry per cycle while no result waits on a stalled
// output, so the table scan sets the time. An insert, or a search by time
// that finds nothing, scans the whole table before it loads its answer. A
// search by time stops at the first matching entry and loads the hit. Read
// or delete by index reads the entry and then loads, and reset and unused
// actions load from the answer state. A result, relocations included, that
// waits on a stalled output holds the block back.
// ----------------------------------------------------------------------------
module timestamp_keyed_flash_slot_table_unit
    import tkfst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ACTION_W-1:0]   action,
    input  logic [TIME_W-1:0]     request_time,
    input  logic [SIDX_W-1:0]     slot_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [STATUS_W-1:0]   status,
    output logic [SIDX_W-1:0]     entry_index,
    output logic [TIME_W-1:0]     entry_time,
    output logic [ADDR_W-1:0]     flash_addr,
    output logic [ADDR_W-1:0]     old_addr,
    output logic                  last
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0]    SCAN_END  = CW'(TABLE_ENTRIES);
    localparam logic [EIU_W-1:0] ENTRY_CAP = EIU_W'(TABLE_ENTRIES);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_INS_FIN = 3'd2;
    localparam logic [2:0] S_IDX_RD  = 3'd3;
    localparam logic [2:0] S_IDX_CHK = 3'd4;
    localparam logic [2:0] S_ANS     = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [ACTION_W-1:0]   action_reg, action_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [SIDX_W-1:0]     sidx_reg, sidx_next;
    logic                  compact_reg, compact_next;
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IW-1:0]         chk_idx_reg, chk_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    logic [WP_W-1:0]       wp_reg, wp_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [STATUS_W-1:0]   ans_status_reg, ans_status_next;

    logic [ADDR_W-1:0]     region_base_reg;
    logic [EIU_W-1:0]      entries_used_reg;
    logic [WP_W-1:0]       region_slots_reg;

    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg, kind_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SIDX_W-1:0]     entry_index_reg, entry_index_next;
    logic [TIME_W-1:0]     entry_time_reg, entry_time_next;
    logic [ADDR_W-1:0]     flash_addr_reg, flash_addr_next;
    logic [ADDR_W-1:0]     old_addr_reg, old_addr_next;
    logic                  last_reg, last_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    entry_t                ram_rdata;

    logic [EIU_W-1:0]      lim;
    logic [ADDR_W-1:0]     slot_addr;
    logic                  out_busy;
    logic                  out_load;
    logic                  is_insert;
    logic                  is_delete;
    logic                  chk_hit;
    logic                  hold;
    logic                  stop;
    logic                  issue;
    logic [IW-1:0]         sidx_idx;

    tkfst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign lim       = (entries_used_reg < ENTRY_CAP) ? entries_used_reg : ENTRY_CAP;
    assign slot_addr = region_base_reg + (ADDR_W'(wp_reg) << SLOT_SHIFT);
    assign out_busy  = out_valid_reg && out_stall;
    assign is_insert = (action_reg == ACT_INSERT);
    assign is_delete = (action_reg == ACT_DEL_TIME) || (action_reg == ACT_DEL_IDX);
    assign chk_hit   = chk_vld_reg && valid_reg[chk_idx_reg];
    assign sidx_idx  = IW'(sidx_reg);
    assign in_stall  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        time_next       = time_reg;
        sidx_next       = sidx_reg;
        compact_next    = compact_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        wp_next         = wp_reg;
        valid_next      = valid_reg;
        ans_status_next = ans_status_reg;

        out_load         = 1'b0;
        kind_next        = KIND_ANSWER;
        status_next      = ST_OK;
        entry_index_next = '0;
        entry_time_next  = '0;
        flash_addr_next  = '0;
        old_addr_next    = '0;
        last_next        = 1'b1;

        ram_we    = 1'b0;
        ram_waddr = chk_idx_reg;
        ram_wdata = '{key: ram_rdata.key, loc: slot_addr};
        ram_re    = 1'b0;
        ram_raddr = scan_idx_reg[IW-1:0];

        hold  = 1'b0;
        stop  = 1'b0;
        issue = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next    = action;
                    time_next      = request_time;
                    sidx_next      = slot_index;
                    compact_next   = 1'b0;
                    scan_idx_next  = '0;
                    chk_vld_next   = 1'b0;
                    free_found_next = 1'b0;
                    case (action)
                        ACT_INSERT:
                        begin
                            if (wp_reg >= region_slots_reg)
                            begin
                                compact_next = 1'b1;
                                wp_next      = '0;
                            end
                            state_next = S_SCAN;
                        end
                        ACT_LOOKUP, ACT_DEL_TIME:
                        begin
                            state_next = S_SCAN;
                        end
                        ACT_READ_IDX, ACT_DEL_IDX:
                        begin
                            if (EIU_W'(slot_index) >= lim)
                            begin
                                ans_status_next = ST_RANGE;
                                state_next      = S_ANS;
                            end
                            else
                            begin
                                state_next = S_IDX_RD;
                            end
                        end
                        ACT_RESET:
                        begin
                            valid_next      = '0;
                            wp_next         = '0;
                            ans_status_next = ST_OK;
                            state_next      = S_ANS;
                        end
                        default:
                        begin
                            ans_status_next = ST_NOT_FOUND;
                            state_next      = S_ANS;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (is_insert)
                    begin
                        if (chk_hit && compact_reg)
                        begin
                            kind_next        = KIND_RELOC;
                            entry_index_next = SIDX_W'(chk_idx_reg);
                            entry_time_next  = ram_rdata.key;
                            flash_addr_next  = slot_addr;
                            old_addr_next    = ram_rdata.loc;
                            last_next        = 1'b0;
                            if (out_busy)
                            begin
                                hold = 1'b1;
                            end
                            else
                            begin
                                out_load = 1'b1;
                                ram_we   = 1'b1;
                                wp_next  = wp_reg + 1'b1;
                            end
                        end
                        if (!valid_reg[chk_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                    else if (chk_hit && (ram_rdata.key == time_reg))
                    begin
                        stop             = 1'b1;
                        entry_index_next = SIDX_W'(chk_idx_reg);
                        if (EIU_W'(chk_idx_reg) >= lim)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            entry_time_next = ram_rdata.key;
                            flash_addr_next = ram_rdata.loc;
                        end
                        if (out_busy)
                        begin
                            hold = 1'b1;
                        end
                        else
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (is_delete && (EIU_W'(chk_idx_reg) < lim))
                            begin
                                valid_next[chk_idx_reg] = 1'b0;
                            end
                        end
                    end
                end

                issue = !hold && !stop && (scan_idx_reg < SCAN_END);
                ram_re = issue;
                if (!hold && !stop)
                begin
                    chk_vld_next  = issue;
                    chk_idx_next  = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(issue);
                end

                if (!chk_vld_reg && (scan_idx_reg == SCAN_END))
                begin
                    if (is_insert)
                    begin
                        state_next = S_INS_FIN;
                    end
                    else
                    begin
                        ans_status_next = ST_NOT_FOUND;
                        state_next      = S_ANS;
                    end
                end
            end

            S_INS_FIN:
            begin
                ram_waddr = free_idx_reg;
                ram_wdata = '{key: time_reg, loc: slot_addr};
                if (free_found_reg && (EIU_W'(free_idx_reg) < lim))
                begin
                    entry_index_next = SIDX_W'(free_idx_reg);
                    entry_time_next  = time_reg;
                    flash_addr_next  = slot_addr;
                    if (!out_busy)
                    begin
                        ram_we                   = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        wp_next                  = wp_reg + 1'b1;
                    end
                end
                else
                begin
                    status_next = ST_NO_FREE;
                end
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_IDX_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = sidx_idx;
                state_next = S_IDX_CHK;
            end

            S_IDX_CHK:
            begin
                entry_index_next = sidx_reg;
                if (!valid_reg[sidx_idx])
                begin
                    status_next = (action_reg == ACT_READ_IDX) ? ST_NOT_FOUND : ST_OK;
                end
                else
                begin
                    entry_time_next = ram_rdata.key;
                    flash_addr_next = ram_rdata.loc;
                    if (is_delete && !out_busy)
                    begin
                        valid_next[sidx_idx] = 1'b0;
                    end
                end
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_ANS:
            begin
                status_next = ans_status_reg;
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            compact_reg    <= 1'b0;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            wp_reg         <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            compact_reg    <= compact_next;
            scan_idx_reg   <= scan_idx_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
            wp_reg         <= wp_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        time_reg       <= time_next;
        sidx_reg       <= sidx_next;
        chk_idx_reg    <= chk_idx_next;
        free_idx_reg   <= free_idx_next;
        ans_status_reg <= ans_status_next;
        if (out_load)
        begin
            kind_reg        <= kind_next;
            status_reg      <= status_next;
            entry_index_reg <= entry_index_next;
            entry_time_reg  <= entry_time_next;
            flash_addr_reg  <= flash_addr_next;
            old_addr_reg    <= old_addr_next;
            last_reg        <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg  <= '0;
            entries_used_reg <= 6'd32;
            region_slots_reg <= 10'd512;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REGION_BASE:  region_base_reg  <= cfg_data;
                CFG_ENTRIES_USED: entries_used_reg <= cfg_data[EIU_W-1:0];
                CFG_REGION_SLOTS: region_slots_reg <= cfg_data[WP_W-1:0];
                default:          ;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign entry_index = entry_index_reg;
    assign entry_time  = entry_time_reg;
    assign flash_addr  = flash_addr_reg;
    assign old_addr    = old_addr_reg;
    assign last        = last_reg;

    // Relocations come only from a compacting insert scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (kind_next == KIND_RELOC)) |-> (state_reg == S_SCAN && compact_reg))
        else $error("relocation outside compaction");

    // Every accepted item leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item not started");

    // Slot pointer holds while the block is idle and not taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !in_valid) |=> (wp_reg == $past(wp_reg)))
        else $error("write pointer moved while idle");

    // Scan counter stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= SCAN_END)
        else $error("scan index beyond table");

endmodule

### verif/timestamp_keyed_flash_slot_table_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_keyed_flash_slot_table_unit_checker
// Watches the request, result and register ports of the slot table, keeps
// its own copy of the table, write pointer and registers, works out the
// replies and relocations of every accepted item and compares each accepted
// result with the oldest one still due.
// ----------------------------------------------------------------------------
module timestamp_keyed_flash_slot_table_unit_checker
    import tkfst_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [ACTION_W-1:0]  action,
    input  logic [TIME_W-1:0]    request_time,
    input  logic [SIDX_W-1:0]    slot_index,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 kind,
    input  logic [STATUS_W-1:0]  status,
    input  logic [SIDX_W-1:0]    entry_index,
    input  logic [TIME_W-1:0]    entry_time,
    input  logic [ADDR_W-1:0]    flash_addr,
    input  logic [ADDR_W-1:0]    old_addr,
    input  logic                 last,
    output int                   error_count,
    output int                   replies_due
);

    localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [SIDX_W-1:0]   index;
        logic [TIME_W-1:0]   etime;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   prior;
        logic                is_last;
    } reply_t;

    reply_t            reply_queue[$];
    logic [31:0]       key_mem[TABLE_ENTRIES];
    logic [ADDR_W-1:0] loc_mem[TABLE_ENTRIES];
    logic [WP_W-1:0]   wr_ptr;
    logic [ADDR_W-1:0] base_cfg;
    logic [EIU_W-1:0]  used_cfg;
    logic [WP_W-1:0]   slots_cfg;

    function automatic void clear_entries();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            key_mem[i] = EMPTY_KEY;
            loc_mem[i] = EMPTY_KEY;
        end
        wr_ptr = '0;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_base_addr(logic [WP_W-1:0] slot);
        return base_cfg + (ADDR_W'(slot) << SLOT_SHIFT);
    endfunction

    function automatic int find_key(logic [31:0] k);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (key_mem[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void post_reply(logic k, logic [STATUS_W-1:0] st,
                                       logic [SIDX_W-1:0] idx, logic [TIME_W-1:0] t,
                                       logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] prior,
                                       logic fin);
        reply_t r;
        r.kind    = k;
        r.status  = st;
        r.index   = idx;
        r.etime   = t;
        r.addr    = addr;
        r.prior   = prior;
        r.is_last = fin;
        reply_queue.push_back(r);
    endfunction

    function automatic void run_table_request(logic [ACTION_W-1:0] act,
                                              logic [TIME_W-1:0] rtime,
                                              logic [SIDX_W-1:0] sidx);
        int                lim;
        int                hit;
        logic [ADDR_W-1:0] na;
        lim = (int'(used_cfg) < TABLE_ENTRIES) ? int'(used_cfg) : TABLE_ENTRIES;
        case (act)
            ACT_INSERT:
            begin
                if (wr_ptr >= slots_cfg)
                begin
                    wr_ptr = '0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (key_mem[i] != EMPTY_KEY)
                        begin
                            na = slot_base_addr(wr_ptr);
                            post_reply(KIND_RELOC, ST_OK, SIDX_W'(i), key_mem[i][TIME_W-1:0],
                                       na, loc_mem[i], 1'b0);
                            loc_mem[i] = na;
                            wr_ptr     = wr_ptr + 1'b1;
                        end
                end
                hit = find_key(EMPTY_KEY);
                if (hit < 0 || hit >= lim)
                    post_reply(KIND_ANSWER, ST_NO_FREE, '0, '0, '0, '0, 1'b1);
                else
                begin
                    na           = slot_base_addr(wr_ptr);
                    key_mem[hit] = {1'b0, rtime};
                    loc_mem[hit] = na;
                    wr_ptr       = wr_ptr + 1'b1;
                    post_reply(KIND_ANSWER, ST_OK, SIDX_W'(hit), rtime, na, '0, 1'b1);
                end
            end
            ACT_LOOKUP, ACT_DEL_TIME:
            begin
                hit = find_key({1'b0, rtime});
                if (hit < 0)
                    post_reply(KIND_ANSWER, ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
                else if (hit >= lim)
                    post_reply(KIND_ANSWER, ST_RANGE, SIDX_W'(hit), '0, '0, '0, 1'b1);
                else
                begin
                    post_reply(KIND_ANSWER, ST_OK, SIDX_W'(hit), key_mem[hit][TIME_W-1:0],
                               loc_mem[hit], '0, 1'b1);
                    if (act == ACT_DEL_TIME)
                    begin
                        key_mem[hit] = EMPTY_KEY;
                        loc_mem[hit] = EMPTY_KEY;
                    end
                end
            end
            ACT_READ_IDX, ACT_DEL_IDX:
            begin
                if (int'(sidx) >= lim)
                    post_reply(KIND_ANSWER, ST_RANGE, '0, '0, '0, '0, 1'b1);
                else if (key_mem[sidx] == EMPTY_KEY)
                    post_reply(KIND_ANSWER, (act == ACT_READ_IDX) ? ST_NOT_FOUND : ST_OK,
                               sidx, '0, '0, '0, 1'b1);
                else
                begin
                    post_reply(KIND_ANSWER, ST_OK, sidx, key_mem[sidx][TIME_W-1:0],
                               loc_mem[sidx], '0, 1'b1);
                    if (act == ACT_DEL_IDX)
                    begin
                        key_mem[sidx] = EMPTY_KEY;
                        loc_mem[sidx] = EMPTY_KEY;
                    end
                end
            end
            ACT_RESET:
            begin
                clear_entries();
                post_reply(KIND_ANSWER, ST_OK, '0, '0, '0, '0, 1'b1);
            end
            default:
                post_reply(KIND_ANSWER, ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            clear_entries();
            base_cfg  = '0;
            used_cfg  = EIU_W'(32);
            slots_cfg = WP_W'(512);
            reply_queue.delete();
            replies_due = 0;
            error_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none due: expected nothing actual kind %0h status %0h index %0h",
                             $time, kind, status, entry_index);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("entry_index", 32'(want.index), 32'(entry_index));
                    check_field("entry_time", 32'(want.etime), 32'(entry_time));
                    check_field("flash_addr", want.addr, flash_addr);
                    check_field("old_addr", want.prior, old_addr);
                    check_field("last", 32'(want.is_last), 32'(last));
                end
            end
            if (cfg_write)
                case (cfg_index)
                    CFG_REGION_BASE:  base_cfg  = cfg_data;
                    CFG_ENTRIES_USED: used_cfg  = cfg_data[EIU_W-1:0];
                    CFG_REGION_SLOTS: slots_cfg = cfg_data[WP_W-1:0];
                    default: ;
                endcase
            if (in_valid && !in_stall)
                run_table_request(action, request_time, slot_index);
            replies_due = reply_queue.size();
        end
    end

endmodule

### verif/timestamp_keyed_flash_slot_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_keyed_flash_slot_table_unit_tb
// Drives the slot table with a short directed sequence (compaction, full
// table, range and empty cases, address wrap, unused actions) and then
// random request mixes under several register settings, with random gaps on
// the request side and random stalls on the result side. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timestamp_keyed_flash_slot_table_unit_tb;
    import tkfst_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_REGION_BASE;
    logic [ADDR_W-1:0]    cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [ACTION_W-1:0]  action       = ACT_INSERT;
    logic [TIME_W-1:0]    request_time = '0;
    logic [SIDX_W-1:0]    slot_index   = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic                 kind;
    logic [STATUS_W-1:0]  status;
    logic [SIDX_W-1:0]    entry_index;
    logic [TIME_W-1:0]    entry_time;
    logic [ADDR_W-1:0]    flash_addr;
    logic [ADDR_W-1:0]    old_addr;
    logic                 last;
    int                   error_count;
    int                   replies_due;

    int                   cycle_count  = 0;
    int                   stall_left   = 0;
    bit                   sender_calm  = 1'b0;
    int                   cur_used     = 32;
    logic [TIME_W-1:0]    recent_times[$];

    timestamp_keyed_flash_slot_table_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (.*);

    timestamp_keyed_flash_slot_table_unit_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) checker_i (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timestamp_keyed_flash_slot_table_unit_tb failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned r;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
            else if (r < 65)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(40, 120);
            end
            else if (r < 93)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 30);
            end
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] t,
                                input logic [SIDX_W-1:0] idx);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        request_time <= t;
        slot_index   <= idx;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (replies_due != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_settings(input logic [ADDR_W-1:0] base, input int used, input int slots);
        cfg_write <= 1'b1;
        cfg_index <= CFG_REGION_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_ENTRIES_USED;
        cfg_data  <= ADDR_W'(used);
        @(posedge clk);
        cfg_index <= CFG_REGION_SLOTS;
        cfg_data  <= ADDR_W'(slots);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_used = used;
    endtask

    function automatic logic [TIME_W-1:0] fresh_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return TIME_W'($urandom_range(0, 255));
        if (r < 40)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return TIME_W'($urandom());
    endfunction

    function automatic logic [TIME_W-1:0] known_time();
        if (recent_times.size() != 0 && $urandom_range(0, 4) != 0)
            return recent_times[$urandom_range(0, recent_times.size() - 1)];
        return fresh_time();
    endfunction

    task automatic random_request();
        int unsigned       r;
        logic [ACTION_W-1:0] act;
        logic [TIME_W-1:0] t;
        logic [SIDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        t = fresh_time();
        if ($urandom_range(0, 3) != 0)
            idx = SIDX_W'($urandom_range(0, cur_used - 1));
        else
            idx = SIDX_W'($urandom_range(0, 31));
        if (r < 42)
        begin
            act = ACT_INSERT;
            recent_times.push_back(t);
            if (recent_times.size() > 16)
                void'(recent_times.pop_front());
        end
        else if (r < 56)
        begin
            act = ACT_LOOKUP;
            t   = known_time();
        end
        else if (r < 66)
            act = ACT_READ_IDX;
        else if (r < 77)
        begin
            act = ACT_DEL_TIME;
            t   = known_time();
        end
        else if (r < 90)
            act = ACT_DEL_IDX;
        else if (r < 92)
            act = ACT_RESET;
        else if (r < 97)
            act = ACT_LOOKUP;
        else
            act = ($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
        send_request(act, t, idx);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        load_settings(32'hFFFF_FE00, 4, 3);
        send_request(ACT_INSERT, '0, '0);
        send_request(ACT_INSERT, '1, 5'd31);
        send_request(ACT_INSERT, 31'd5, '0);
        send_request(ACT_LOOKUP, '1, '0);
        send_request(ACT_LOOKUP, 31'h0001_2345, '0);
        send_request(ACT_READ_IDX, '0, 5'd1);
        send_request(ACT_READ_IDX, '0, 5'd3);
        send_request(ACT_READ_IDX, '0, 5'd31);
        send_request(ACT_DEL_IDX, '0, 5'd3);
        send_request(ACT_DEL_TIME, '0, '0);
        send_request(ACT_INSERT, 31'd9, '0);
        send_request(ACT_INSERT, 31'd11, '0);
        send_request(ACT_INSERT, 31'd13, '0);
        send_request(ACT_DEL_IDX, '0, 5'd30);
        send_request(ACT_DEL_TIME, 31'h0000_0777, '0);
        send_request(ACT_SPARE_A, '1, '1);
        send_request(ACT_SPARE_B, '0, '0);
        send_request(ACT_RESET, '0, '0);
        send_request(ACT_LOOKUP, 31'd9, '0);
        drain_replies();

        load_settings('0, 32, 1);
        send_request(ACT_INSERT, 31'd100, '0);
        send_request(ACT_INSERT, 31'd101, '0);
        send_request(ACT_INSERT, 31'd102, '0);
        drain_replies();
        load_settings('0, 1, 1);
        send_request(ACT_LOOKUP, 31'd102, '0);
        send_request(ACT_DEL_TIME, 31'd101, '0);
        send_request(ACT_READ_IDX, '0, '0);

        for (int phase = 0; phase < 6; phase++)
        begin
            drain_replies();
            case (phase)
                0:       load_settings($urandom(), 32, 512);
                1:       load_settings(32'hFFFF_FFFF, 1, 1);
                2:       load_settings($urandom(), $urandom_range(1, 32), $urandom_range(1, 24));
                3:       load_settings('0, 32, 2);
                4:       load_settings($urandom(), $urandom_range(2, 32), $urandom_range(1, 512));
                default: load_settings($urandom(), 16, $urandom_range(4, 40));
            endcase
            sender_calm = (phase == 2);
            repeat (34) random_request();
        end

        drain_replies();
        repeat (40) @(posedge clk);
        if (error_count == 0 && replies_due == 0)
            $display("timestamp_keyed_flash_slot_table_unit_tb passed");
        else
            $display("timestamp_keyed_flash_slot_table_unit_tb failed");
        $finish;
    end

endmodule
